// ===== design/rmrp_pkg.sv =====
// ----------------------------------------------------------------------------
// rmrp_pkg
// Shared widths, codes and word types of the multibulk request parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rmrp_pkg;

   localparam int ByteW     = 8;
   localparam int IndexW    = 20;
   localparam int CountW    = 21;
   localparam int LengthW   = 30;
   localparam int CsrIndexW = 2;
   localparam int CsrDataW  = 32;

   localparam logic [LengthW-1:0] ValueMax           = 30'h3FFF_FFFF;
   localparam logic [CountW-1:0]  ResetMaxArgCount   = 21'h10_0000;
   localparam logic [LengthW-1:0] ResetMaxBulkLength = 30'h2000_0000;

   localparam logic [ByteW-1:0] CharStar   = 8'h2A;
   localparam logic [ByteW-1:0] CharDollar = 8'h24;
   localparam logic [ByteW-1:0] CharCr     = 8'h0D;
   localparam logic [ByteW-1:0] CharMinus  = 8'h2D;
   localparam logic [ByteW-1:0] CharZero   = 8'h30;
   localparam logic [ByteW-1:0] CharNine   = 8'h39;

   typedef enum logic [2:0] {
      EV_NONE      = 3'd0,
      EV_ARG_BYTE  = 3'd1,
      EV_ARG_END   = 3'd2,
      EV_CMD_DONE  = 3'd3,
      EV_PROTO_ERR = 3'd4
   } event_type;

   typedef enum logic [CsrIndexW-1:0] {
      REG_MAX_ARG_COUNT   = 2'd0,
      REG_MAX_BULK_LENGTH = 2'd1
   } csr_reg_type;

   typedef struct packed {
      logic [CountW-1:0]  max_arg_count;
      logic [LengthW-1:0] max_bulk_length;
   } cfg_type;

   typedef struct packed {
      event_type          event_res;
      logic [ByteW-1:0]   arg_byte;
      logic [IndexW-1:0]  arg_index;
      logic [CountW-1:0]  arg_count;
   } rsp_word_type;

   typedef struct packed {
      logic         valid;
      rsp_word_type word;
   } rsp_push_type;

endpackage

`default_nettype wire

// ===== design/rmrp_req_if.sv =====
// ----------------------------------------------------------------------------
// rmrp_req_if
// Request byte channel: valid, ready and one raw stream byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmrp_req_if
   import rmrp_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// ===== design/rmrp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rmrp_rsp_if
// Result channel: valid, ready and one parser event word.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmrp_rsp_if
   import rmrp_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [2:0]        event_res;
   logic [ByteW-1:0]  arg_byte;
   logic [IndexW-1:0] arg_index;
   logic [CountW-1:0] arg_count;

   modport source (output valid, output event_res, output arg_byte, output arg_index,
                   output arg_count, input ready);
   modport sink   (input valid, input event_res, input arg_byte, input arg_index,
                   input arg_count, output ready);
endinterface

`default_nettype wire

// ===== design/rmrp_csr_if.sv =====
// ----------------------------------------------------------------------------
// rmrp_csr_if
// Configuration write channel: valid, ready, register index and data.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmrp_csr_if
   import rmrp_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [CsrIndexW-1:0] index;
   logic [CsrDataW-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/rmrp_csr.sv =====
// ----------------------------------------------------------------------------
// rmrp_csr
// Limit registers for argument count and bulk length, written by index.
// ----------------------------------------------------------------------------
`default_nettype none

module rmrp_csr
   import rmrp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   input  wire logic [CsrIndexW-1:0] csr_index,
   input  wire logic [CsrDataW-1:0]  csr_data,
   output      logic                 csr_ready,
   output      cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_MAX_ARG_COUNT:   cfg_in.max_arg_count   = csr_data[CountW-1:0];
            REG_MAX_BULK_LENGTH: cfg_in.max_bulk_length = csr_data[LengthW-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_arg_count   <= ResetMaxArgCount;
         cfg_ff.max_bulk_length <= ResetMaxBulkLength;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/rmrp_parser.sv =====
// ----------------------------------------------------------------------------
// rmrp_parser
// Input byte register and request state machine with number accumulator
// and argument counters; one byte handled per cycle while out_room is set.
// ----------------------------------------------------------------------------
`default_nettype none

module rmrp_parser
   import rmrp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cfg_type          cfg,
   input  wire logic             req_valid,
   input  wire logic [ByteW-1:0] req_byte,
   output      logic             req_ready,
   input  wire logic             out_room,
   output      rsp_push_type     push
);

   typedef enum logic [10:0] {
      PH_STAR       = 11'b000_0000_0001,
      PH_COUNT      = 11'b000_0000_0010,
      PH_SKIP_COUNT = 11'b000_0000_0100,
      PH_SKIP_EMPTY = 11'b000_0000_1000,
      PH_DOLLAR     = 11'b000_0001_0000,
      PH_LEN        = 11'b000_0010_0000,
      PH_SKIP_LEN   = 11'b000_0100_0000,
      PH_DATA       = 11'b000_1000_0000,
      PH_TRAIL1     = 11'b001_0000_0000,
      PH_TRAIL2     = 11'b010_0000_0000,
      PH_ERROR      = 11'b100_0000_0000
   } phase_type;

   typedef enum logic [1:0] {
      DS_NONE   = 2'd0,
      DS_ZERO   = 2'd1,
      DS_DIGITS = 2'd2,
      DS_BAD    = 2'd3
   } digit_status_type;

   typedef struct packed {
      logic [LengthW-1:0] value;
      logic               too_big;
      logic               negative;
      digit_status_type   status;
   } num_type;

   localparam num_type NumClear = '{value: '0, too_big: 1'b0, negative: 1'b0,
                                    status: DS_NONE};

   function automatic num_type number_feed(num_type n, logic [ByteW-1:0] c);
      num_type        r;
      logic [3:0]     d;
      logic [33:0]    x10;
      r   = n;
      d   = c[3:0];
      x10 = {1'b0, n.value, 3'b000} + {3'b000, n.value, 1'b0} + {30'd0, d};
      if (c == CharMinus) begin
         if (n.status == DS_NONE && !n.negative) begin
            r.negative = 1'b1;
         end else begin
            r.status = DS_BAD;
         end
      end else if (c inside {[CharZero:CharNine]}) begin
         if (n.status == DS_NONE) begin
            if (d == 4'd0) begin
               r.status = n.negative ? DS_BAD : DS_ZERO;
            end else begin
               r.status = DS_DIGITS;
               r.value  = {26'd0, d};
            end
         end else if (n.status == DS_ZERO) begin
            r.status = DS_BAD;
         end else if (n.status == DS_DIGITS && !n.too_big) begin
            if (x10 > {4'd0, ValueMax}) begin
               r.too_big = 1'b1;
               r.value   = ValueMax;
            end else begin
               r.value = x10[LengthW-1:0];
            end
         end
      end else begin
         r.status = DS_BAD;
      end
      return r;
   endfunction

   logic               in_valid_ff, in_valid_in;
   logic [ByteW-1:0]   in_byte_ff;
   logic               fire;

   phase_type          phase_ff, phase_in;
   num_type            num_ff, num_in;
   logic [CountW-1:0]  args_left_ff, args_left_in;
   logic [IndexW-1:0]  current_arg_ff, current_arg_in;
   logic [CountW-1:0]  total_args_ff, total_args_in;
   logic [LengthW-1:0] bytes_left_ff, bytes_left_in;

   logic               num_ok;
   logic [LengthW-1:0] bytes_dec;
   rsp_word_type       word;

   // input byte register
   assign fire        = in_valid_ff && out_room;
   assign req_ready   = !in_valid_ff || fire;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_byte;
      end
   end

   // state machine
   assign num_ok    = (num_ff.status == DS_ZERO) || (num_ff.status == DS_DIGITS);
   assign bytes_dec = (bytes_left_ff != '0) ? bytes_left_ff - 30'd1 : bytes_left_ff;

   always_comb begin
      phase_in       = phase_ff;
      num_in         = num_ff;
      args_left_in   = args_left_ff;
      current_arg_in = current_arg_ff;
      total_args_in  = total_args_ff;
      bytes_left_in  = bytes_left_ff;
      word           = '{event_res: EV_NONE, arg_byte: '0, arg_index: '0, arg_count: '0};

      case (phase_ff)
         PH_STAR: begin
            if (in_byte_ff == CharStar) begin
               num_in   = NumClear;
               phase_in = PH_COUNT;
            end else begin
               phase_in = PH_ERROR;
            end
         end
         PH_COUNT: begin
            if (in_byte_ff != CharCr) begin
               num_in = number_feed(num_ff, in_byte_ff);
            end else if (!num_ok) begin
               phase_in = PH_ERROR;
            end else if (num_ff.negative || num_ff.value == '0) begin
               word.event_res = EV_CMD_DONE;
               phase_in       = PH_SKIP_EMPTY;
            end else if (num_ff.too_big ||
                         num_ff.value > {9'd0, cfg.max_arg_count}) begin
               phase_in = PH_ERROR;
            end else begin
               total_args_in  = num_ff.value[CountW-1:0];
               args_left_in   = num_ff.value[CountW-1:0];
               current_arg_in = '0;
               phase_in       = PH_SKIP_COUNT;
            end
         end
         PH_SKIP_COUNT: phase_in = PH_DOLLAR;
         PH_SKIP_EMPTY: phase_in = PH_STAR;
         PH_DOLLAR: begin
            if (in_byte_ff == CharDollar) begin
               num_in   = NumClear;
               phase_in = PH_LEN;
            end else begin
               phase_in = PH_ERROR;
            end
         end
         PH_LEN: begin
            if (in_byte_ff != CharCr) begin
               num_in = number_feed(num_ff, in_byte_ff);
            end else if (!num_ok || num_ff.negative || num_ff.too_big ||
                         num_ff.value > cfg.max_bulk_length) begin
               phase_in = PH_ERROR;
            end else begin
               bytes_left_in = num_ff.value;
               phase_in      = PH_SKIP_LEN;
            end
         end
         PH_SKIP_LEN: begin
            phase_in = (bytes_left_ff == '0) ? PH_TRAIL1 : PH_DATA;
         end
         PH_DATA: begin
            word.event_res = EV_ARG_BYTE;
            word.arg_byte  = in_byte_ff;
            word.arg_index = current_arg_ff;
            bytes_left_in  = bytes_dec;
            if (bytes_dec == '0) begin
               phase_in = PH_TRAIL1;
            end
         end
         PH_TRAIL1: begin
            word.event_res = EV_ARG_END;
            word.arg_index = current_arg_ff;
            if (args_left_ff != '0) begin
               args_left_in = args_left_ff - 21'd1;
            end
            phase_in = PH_TRAIL2;
         end
         PH_TRAIL2: begin
            if (args_left_ff == '0) begin
               word.event_res = EV_CMD_DONE;
               word.arg_count = total_args_ff;
               phase_in       = PH_STAR;
            end else begin
               current_arg_in = current_arg_ff + 20'd1;
               phase_in       = PH_DOLLAR;
            end
         end
         default: phase_in = PH_ERROR;
      endcase

      if (phase_in == PH_ERROR) begin
         word = '{event_res: EV_PROTO_ERR, arg_byte: '0, arg_index: '0, arg_count: '0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_STAR;
         num_ff         <= NumClear;
         args_left_ff   <= '0;
         current_arg_ff <= '0;
         total_args_ff  <= '0;
         bytes_left_ff  <= '0;
      end else if (fire) begin
         phase_ff       <= phase_in;
         num_ff         <= num_in;
         args_left_ff   <= args_left_in;
         current_arg_ff <= current_arg_in;
         total_args_ff  <= total_args_in;
         bytes_left_ff  <= bytes_left_in;
      end
   end

   assign push.valid = fire;
   assign push.word  = word;

endmodule

`default_nettype wire

// ===== design/rmrp_out_buf.sv =====
// ----------------------------------------------------------------------------
// rmrp_out_buf
// Two-word result register with skid stage; room is taken from registered
// state only, so ready does not ripple back from the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module rmrp_out_buf
   import rmrp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire rsp_push_type push,
   output      logic         room,
   output      logic         rsp_valid,
   input  wire logic         rsp_ready,
   output      rsp_word_type rsp_word
);

   logic [1:0]   count_ff, count_in;
   rsp_word_type head_ff, head_in;
   rsp_word_type tail_ff, tail_in;
   logic         pop;

   assign room      = (count_ff != 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_word  = head_ff;
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      case (count_ff)
         2'd0: begin
            if (push.valid) begin
               head_in  = push.word;
               count_in = 2'd1;
            end
         end
         2'd1: begin
            if (push.valid && pop) begin
               head_in = push.word;
            end else if (push.valid) begin
               tail_in  = push.word;
               count_in = 2'd2;
            end else if (pop) begin
               count_in = 2'd0;
            end
         end
         2'd2: begin
            if (pop) begin
               head_in  = tail_ff;
               count_in = 2'd1;
            end
         end
         default: count_in = 2'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

`default_nettype wire

// ===== design/resp_multibulk_request_parser_core.sv =====
// ----------------------------------------------------------------------------
// resp_multibulk_request_parser_core
// Streaming parser for multibulk requests, one stream byte per word.
//
// req_chan carries raw request bytes, rsp_chan one event word per byte
// (nothing, argument byte, argument end, command complete, protocol error)
// and csr_chan writes the argument count and bulk length limits by index.
// An accepted byte sits in the input register until the result register
// has room, is then parsed and its word written to the result register,
// which drives rsp_chan. One byte is taken every cycle while the result
// register has room; the state machine and its counters update together.
// Reset returns the parser to waiting for '*', clears all counters and
// loads the default limits. A protocol error holds until reset. When the
// receiver stalls, two words queue in the result stage and one byte in the
// input register before req_chan ready drops; after a stall clears,
// parsing resumes once the registered room of the result stage returns.
// ----------------------------------------------------------------------------
`default_nettype none

module resp_multibulk_request_parser_core
   import rmrp_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   rmrp_req_if.sink    req_chan,
   rmrp_rsp_if.source  rsp_chan,
   rmrp_csr_if.sink    csr_chan
);

   cfg_type      cfg;
   rsp_push_type push;
   logic         room;
   logic         parser_ready;
   logic         csr_ready;
   logic         rsp_valid;
   rsp_word_type rsp_word;

   rmrp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_chan.valid),
      .csr_index (csr_chan.index),
      .csr_data  (csr_chan.data),
      .csr_ready (csr_ready),
      .cfg       (cfg)
   );

   rmrp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_chan.valid),
      .req_byte  (req_chan.in_byte),
      .req_ready (parser_ready),
      .out_room  (room),
      .push      (push)
   );

   rmrp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_word  (rsp_word)
   );

   assign csr_chan.ready     = csr_ready;
   assign req_chan.ready     = parser_ready;
   assign rsp_chan.valid     = rsp_valid;
   assign rsp_chan.event_res = rsp_word.event_res;
   assign rsp_chan.arg_byte  = rsp_word.arg_byte;
   assign rsp_chan.arg_index = rsp_word.arg_index;
   assign rsp_chan.arg_count = rsp_word.arg_count;

endmodule

`default_nettype wire

// ===== design/rmrp_checker.sv =====
// ----------------------------------------------------------------------------
// rmrp_checker
// Port-level checks on the result channel of the request parser, bound to
// the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rmrp_checker
   import rmrp_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [2:0]        rsp_event_res,
   input wire logic [ByteW-1:0]  rsp_arg_byte,
   input wire logic [IndexW-1:0] rsp_arg_index,
   input wire logic [CountW-1:0] rsp_arg_count
);

   logic err_seen_ff;

   // an error word has been taken since reset
   always_ff @(posedge clock) begin
      if (reset) begin
         err_seen_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready && rsp_event_res == EV_PROTO_ERR) begin
         err_seen_ff <= 1'b1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({rsp_event_res, rsp_arg_byte, rsp_arg_index, rsp_arg_count}))
      else $error("result word changed while stalled");

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && err_seen_ff |-> rsp_event_res == EV_PROTO_ERR)
      else $error("word other than error after protocol error");

   a_byte_only_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != EV_ARG_BYTE |-> rsp_arg_byte == '0)
      else $error("argument byte set outside a data word");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

bind resp_multibulk_request_parser_core rmrp_checker u_rmrp_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_event_res (rsp_chan.event_res),
   .rsp_arg_byte  (rsp_chan.arg_byte),
   .rsp_arg_index (rsp_chan.arg_index),
   .rsp_arg_count (rsp_chan.arg_count)
);

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multibulk request parser core.
//
// Request bytes are driven through the req channel and every accepted byte
// is run through a local parser model; its word, or a table row's own, is
// queued and compared field by field with each word taken from the rsp
// channel. A short table of hand-made requests comes first, then random
// well-formed requests under several limit settings and idle patterns, and
// last one broken request, since a protocol error holds until reset.
// ----------------------------------------------------------------------------

module testbench;
   import rmrp_pkg::*;

   localparam int CycleLimit = 200000;

   typedef enum logic [3:0] {
      ST_STAR, ST_COUNT, ST_SKIP_COUNT, ST_SKIP_EMPTY, ST_DOLLAR, ST_LEN,
      ST_SKIP_LEN, ST_DATA, ST_TRAIL1, ST_TRAIL2, ST_ERROR
   } parse_state_type;

   typedef enum logic [1:0] {DG_NONE, DG_ZERO, DG_DIGITS, DG_BAD} digit_state_type;

   typedef struct packed {
      logic [ByteW-1:0] in_byte;
      logic             typed;
      rsp_word_type     want;
   } stim_row_type;

   localparam rsp_word_type WordNone  = '{EV_NONE, 8'h00, 20'd0, 21'd0};
   localparam rsp_word_type WordError = '{EV_PROTO_ERR, 8'h00, 20'd0, 21'd0};
   localparam rsp_word_type WordEmpty = '{EV_CMD_DONE, 8'h00, 20'd0, 21'd0};

   localparam stim_row_type DirectedRows [27] = '{
      // lone zero count
      '{CharStar,  1'b1, WordNone},
      '{CharZero,  1'b1, WordNone},
      '{CharCr,    1'b1, WordEmpty},
      '{8'hFF,     1'b1, WordNone},
      // negative count
      '{CharStar,  1'b1, WordNone},
      '{CharMinus, 1'b1, WordNone},
      '{8'h37,     1'b1, WordNone},
      '{CharCr,    1'b1, WordEmpty},
      '{8'h00,     1'b1, WordNone},
      // two arguments, the first one empty
      '{CharStar,  1'b1, WordNone},
      '{8'h32,     1'b1, WordNone},
      '{CharCr,    1'b1, WordNone},
      '{8'h0A,     1'b1, WordNone},
      '{CharDollar, 1'b1, WordNone},
      '{CharZero,  1'b1, WordNone},
      '{CharCr,    1'b1, WordNone},
      '{8'h0A,     1'b1, WordNone},
      '{8'h00,     1'b0, WordNone},
      '{8'hFF,     1'b0, WordNone},
      '{CharDollar, 1'b1, WordNone},
      '{8'h32,     1'b1, WordNone},
      '{CharCr,    1'b1, WordNone},
      '{8'h0A,     1'b1, WordNone},
      '{8'h00,     1'b1, '{EV_ARG_BYTE, 8'h00, 20'd1, 21'd0}},
      '{8'hFF,     1'b1, '{EV_ARG_BYTE, 8'hFF, 20'd1, 21'd0}},
      '{CharCr,    1'b0, WordNone},
      '{8'h0A,     1'b0, WordNone}
   };

   localparam int unsigned ArgLimits [6] = '{1048576, 0, 1, 3, 2, 1048576};
   localparam int unsigned LenLimits [6] = '{536870912, 536870912, 0, 8, 1, 536870912};

   logic clock = 1'b0;
   logic reset = 1'b1;

   rmrp_req_if req_chan ();
   rmrp_rsp_if rsp_chan ();
   rmrp_csr_if csr_chan ();

   resp_multibulk_request_parser_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // parser model state
   cfg_type            limits;
   parse_state_type    st;
   logic [LengthW-1:0] num_value;
   logic               num_big;
   logic               num_neg;
   digit_state_type    num_digits;
   logic [CountW-1:0]  args_left;
   logic [CountW-1:0]  total_args;
   logic [IndexW-1:0]  arg_no;
   logic [LengthW-1:0] data_left;

   rsp_word_type     pending_events [$];
   logic [ByteW-1:0] request_bytes [$];
   rsp_word_type     want;
   int               bytes_sent = 0;
   int               send_idle_pct = 0;
   int               rsp_stall_pct = 0;
   int               cycle_count = 0;
   bit               failed = 1'b0;

   always #2 clock = ~clock;

   function automatic void clear_number();
      num_value  = '0;
      num_big    = 1'b0;
      num_neg    = 1'b0;
      num_digits = DG_NONE;
   endfunction

   function automatic void take_number_char(logic [ByteW-1:0] c);
      logic [3:0] d;
      d = 4'(c - CharZero);
      if (c == CharMinus) begin
         if (num_digits == DG_NONE && !num_neg) num_neg = 1'b1;
         else num_digits = DG_BAD;
      end else if (c >= CharZero && c <= CharNine) begin
         if (num_digits == DG_NONE) begin
            if (d == 0) begin
               num_digits = num_neg ? DG_BAD : DG_ZERO;
            end else begin
               num_digits = DG_DIGITS;
               num_value  = LengthW'(d);
            end
         end else if (num_digits == DG_ZERO) begin
            num_digits = DG_BAD;
         end else if (num_digits == DG_DIGITS && !num_big) begin
            if (num_value > (ValueMax - d) / 10) begin
               num_big   = 1'b1;
               num_value = ValueMax;
            end else begin
               num_value = num_value * 10 + d;
            end
         end
      end else begin
         num_digits = DG_BAD;
      end
   endfunction

   function automatic rsp_word_type parse_byte(logic [ByteW-1:0] c);
      rsp_word_type w;
      w = WordNone;
      case (st)
         ST_STAR: begin
            if (c == CharStar) begin
               clear_number();
               st = ST_COUNT;
            end else begin
               st = ST_ERROR;
            end
         end
         ST_COUNT: begin
            if (c != CharCr) begin
               take_number_char(c);
            end else if (!(num_digits inside {DG_ZERO, DG_DIGITS})) begin
               st = ST_ERROR;
            end else if (num_neg || num_value == 0) begin
               w.event_res = EV_CMD_DONE;
               st = ST_SKIP_EMPTY;
            end else if (num_big || num_value > limits.max_arg_count) begin
               st = ST_ERROR;
            end else begin
               total_args = CountW'(num_value);
               args_left  = CountW'(num_value);
               arg_no     = '0;
               st = ST_SKIP_COUNT;
            end
         end
         ST_SKIP_COUNT: st = ST_DOLLAR;
         ST_SKIP_EMPTY: st = ST_STAR;
         ST_DOLLAR: begin
            if (c == CharDollar) begin
               clear_number();
               st = ST_LEN;
            end else begin
               st = ST_ERROR;
            end
         end
         ST_LEN: begin
            if (c != CharCr) begin
               take_number_char(c);
            end else if (!(num_digits inside {DG_ZERO, DG_DIGITS}) || num_neg || num_big ||
                         num_value > limits.max_bulk_length) begin
               st = ST_ERROR;
            end else begin
               data_left = num_value;
               st = ST_SKIP_LEN;
            end
         end
         ST_SKIP_LEN: st = (data_left == 0) ? ST_TRAIL1 : ST_DATA;
         ST_DATA: begin
            w.event_res = EV_ARG_BYTE;
            w.arg_byte  = c;
            w.arg_index = arg_no;
            if (data_left != 0) data_left = data_left - 1'b1;
            if (data_left == 0) st = ST_TRAIL1;
         end
         ST_TRAIL1: begin
            w.event_res = EV_ARG_END;
            w.arg_index = arg_no;
            if (args_left != 0) args_left = args_left - 1'b1;
            st = ST_TRAIL2;
         end
         ST_TRAIL2: begin
            if (args_left == 0) begin
               w.event_res = EV_CMD_DONE;
               w.arg_count = total_args;
               st = ST_STAR;
            end else begin
               arg_no = arg_no + 1'b1;
               st = ST_DOLLAR;
            end
         end
         default: st = ST_ERROR;
      endcase
      if (st == ST_ERROR) w = WordError;
      return w;
   endfunction

   task automatic send_byte(input logic [ByteW-1:0] b, input logic typed,
                            input rsp_word_type typed_word);
      rsp_word_type w;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.in_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      w = parse_byte(b);
      pending_events.push_back(typed ? typed_word : w);
      bytes_sent++;
   endtask

   task automatic send_queued_bytes();
      while (request_bytes.size() != 0) send_byte(request_bytes.pop_front(), 1'b0, WordNone);
   endtask

   task automatic wait_until_drained();
      req_chan.valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input csr_reg_type idx, input logic [CsrDataW-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      if (idx == REG_MAX_ARG_COUNT) limits.max_arg_count = value[CountW-1:0];
      else limits.max_bulk_length = value[LengthW-1:0];
   endtask

   function automatic void push_decimal(longint unsigned v);
      logic [ByteW-1:0] digits [$];
      if (v == 0) digits.push_front(CharZero);
      while (v != 0) begin
         digits.push_front(8'(CharZero + v % 10));
         v = v / 10;
      end
      foreach (digits[i]) request_bytes.push_back(digits[i]);
   endfunction

   function automatic void push_random(int unsigned n);
      repeat (n) request_bytes.push_back(8'($urandom_range(0, 255)));
   endfunction

   task automatic send_random_command();
      int unsigned n_args;
      int unsigned len;
      int unsigned cap;
      request_bytes.push_back(CharStar);
      if (limits.max_arg_count == 0 || $urandom_range(0, 5) == 0) begin
         // empty command, negative counts may saturate
         case ($urandom_range(0, 2))
            0: push_decimal(0);
            1: begin
               request_bytes.push_back(CharMinus);
               push_decimal($urandom_range(1, 999));
            end
            default: begin
               request_bytes.push_back(CharMinus);
               push_decimal({$urandom, $urandom} % 64'd999_999_999_999_999 + 1);
            end
         endcase
         request_bytes.push_back(CharCr);
         push_random(1);
      end else begin
         cap = (limits.max_arg_count < 4) ? limits.max_arg_count : 4;
         n_args = $urandom_range(1, cap);
         push_decimal(n_args);
         request_bytes.push_back(CharCr);
         push_random(1);
         repeat (n_args) begin
            cap = (limits.max_bulk_length < 12) ? limits.max_bulk_length : 12;
            if ($urandom_range(0, 7) == 0) len = cap;
            else len = $urandom_range(0, (cap < 5) ? cap : 5);
            request_bytes.push_back(CharDollar);
            push_decimal(len);
            request_bytes.push_back(CharCr);
            push_random(1 + len + 2);
         end
      end
      send_queued_bytes();
   endtask

   task automatic send_broken_request();
      logic [ByteW-1:0] b;
      case ($urandom_range(0, 7))
         0: begin
            do b = 8'($urandom_range(0, 255)); while (b == CharStar);
            request_bytes.push_back(b);
         end
         1: begin
            request_bytes.push_back(CharStar);
            push_decimal(1);
            request_bytes.push_back(CharCr);
            push_random(1);
            do b = 8'($urandom_range(0, 255)); while (b == CharDollar);
            request_bytes.push_back(b);
         end
         2: begin
            request_bytes.push_back(CharStar);
            case ($urandom_range(0, 4))
               0: begin
                  request_bytes.push_back(CharZero);
                  request_bytes.push_back(8'($urandom_range(CharZero, CharNine)));
               end
               1: begin
                  request_bytes.push_back(CharMinus);
                  request_bytes.push_back(CharZero);
               end
               2: request_bytes.push_back(CharMinus);
               3: ;
               default: begin
                  request_bytes.push_back(8'h35);
                  do b = 8'($urandom_range(0, 255));
                  while ((b >= CharZero && b <= CharNine) || b == CharCr);
                  request_bytes.push_back(b);
               end
            endcase
            request_bytes.push_back(CharCr);
         end
         3: begin
            request_bytes.push_back(CharStar);
            push_decimal(1);
            request_bytes.push_back(CharCr);
            push_random(1);
            request_bytes.push_back(CharDollar);
            request_bytes.push_back(CharMinus);
            push_decimal($urandom_range(1, 99));
            request_bytes.push_back(CharCr);
         end
         4: begin
            request_bytes.push_back(CharStar);
            push_decimal(limits.max_arg_count + 1);
            request_bytes.push_back(CharCr);
         end
         5: begin
            request_bytes.push_back(CharStar);
            push_decimal(64'd1_073_741_824 + $urandom);
            request_bytes.push_back(CharCr);
         end
         6: begin
            request_bytes.push_back(CharStar);
            push_decimal(1);
            request_bytes.push_back(CharCr);
            push_random(1);
            request_bytes.push_back(CharDollar);
            push_decimal(limits.max_bulk_length + 1);
            request_bytes.push_back(CharCr);
         end
         default: begin
            request_bytes.push_back(CharStar);
            push_decimal(1);
            request_bytes.push_back(CharCr);
            push_random(1);
            request_bytes.push_back(CharDollar);
            push_decimal({$urandom, $urandom} % 64'd99_999_999_999 + 64'd1_073_741_824);
            request_bytes.push_back(CharCr);
         end
      endcase
      // error holds for whatever follows
      push_random($urandom_range(3, 8));
      send_queued_bytes();
   endtask

   // result word checker and receiver stalls
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_events.size() == 0) begin
               $error("result word with nothing expected");
               failed = 1'b1;
            end else begin
               want = pending_events.pop_front();
               if (rsp_chan.event_res !== want.event_res) begin
                  $error("event_res: expected %0d, got %0d", want.event_res, rsp_chan.event_res);
                  failed = 1'b1;
               end
               if (rsp_chan.arg_byte !== want.arg_byte) begin
                  $error("arg_byte: expected %0h, got %0h", want.arg_byte, rsp_chan.arg_byte);
                  failed = 1'b1;
               end
               if (rsp_chan.arg_index !== want.arg_index) begin
                  $error("arg_index: expected %0d, got %0d", want.arg_index, rsp_chan.arg_index);
                  failed = 1'b1;
               end
               if (rsp_chan.arg_count !== want.arg_count) begin
                  $error("arg_count: expected %0d, got %0d", want.arg_count, rsp_chan.arg_count);
                  failed = 1'b1;
               end
            end
         end
         rsp_chan.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("testbench failed");
         $finish;
      end
   end

   initial begin
      int seg;
      int seg_start;
      req_chan.valid   = 1'b0;
      req_chan.in_byte = '0;
      rsp_chan.ready   = 1'b0;
      csr_chan.valid   = 1'b0;
      csr_chan.index   = REG_MAX_ARG_COUNT;
      csr_chan.data    = '0;
      limits.max_arg_count   = ResetMaxArgCount;
      limits.max_bulk_length = ResetMaxBulkLength;
      st = ST_STAR;
      clear_number();
      args_left  = '0;
      total_args = '0;
      arg_no     = '0;
      data_left  = '0;
      send_idle_pct = 13;
      rsp_stall_pct = 63;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (DirectedRows[i])
         send_byte(DirectedRows[i].in_byte, DirectedRows[i].typed, DirectedRows[i].want);

      for (seg = 0; seg < 6; seg++) begin
         wait_until_drained();
         write_reg(REG_MAX_ARG_COUNT, ArgLimits[seg]);
         write_reg(REG_MAX_BULK_LENGTH, LenLimits[seg]);
         case (seg / 2)
            0: begin
               send_idle_pct = 13;
               rsp_stall_pct = 63;
            end
            1: begin
               send_idle_pct = 63;
               rsp_stall_pct = 13;
            end
            default: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         seg_start = bytes_sent;
         while (bytes_sent - seg_start < 108) send_random_command();
      end
      send_broken_request();

      wait_until_drained();
      repeat (10) @(posedge clock);
      if (!failed) $display("testbench passed");
      else $display("testbench failed");
      $finish;
   end

endmodule
